// ===== hw/rtl/gglw_pkg.sv =====
// ----------------------------------------------------------------------------
// gglw_pkg
// Shared types and constants of the greedy glyph line wrapper: item kinds,
// result kinds, register indexes, reset values and port widths.
// ----------------------------------------------------------------------------
package gglw_pkg;

  // request kinds on the input stream
  typedef enum logic [1:0] {
    FUNC_GLYPH   = 2'd0,
    FUNC_NEWLINE = 2'd1,
    FUNC_END     = 2'd2
  } func_t;

  // result kinds on the output stream
  localparam logic KIND_GLYPH   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // configuration register indexes
  localparam logic [2:0] REG_GLYPH_WIDTH  = 3'd0;
  localparam logic [2:0] REG_GLYPH_HEIGHT = 3'd1;
  localparam logic [2:0] REG_LINE_HEIGHT  = 3'd2;
  localparam logic [2:0] REG_LINE_SPACING = 3'd3;
  localparam logic [2:0] REG_WRAP_WIDTH   = 3'd4;

  // register reset values
  localparam logic [7:0]  GLYPH_WIDTH_RST  = 8'd8;
  localparam logic [7:0]  GLYPH_HEIGHT_RST = 8'd16;
  localparam logic [7:0]  LINE_HEIGHT_RST  = 8'd16;
  localparam logic [7:0]  LINE_SPACING_RST = 8'd0;
  localparam logic [15:0] WRAP_WIDTH_RST   = 16'd0;

  // port widths
  localparam int CP_W       = 21;
  localparam int IN_DATA_W  = 40;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 104;
  localparam int OUT_USER_W = 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

endpackage

// ===== hw/rtl/greedy_glyph_line_wrapper_core.sv =====
// ----------------------------------------------------------------------------
// greedy_glyph_line_wrapper_core
// Greedy line wrapper for a stream of decoded glyphs, newlines and
// end-of-text markers; emits glyph placements and a text summary.
// ----------------------------------------------------------------------------
// One request is taken every cycle unless the output stalls. A request is
// captured in an input stage register; once the output register can take a
// result, the pen, line and widest-line state is updated while any placement
// or summary is loaded into the output register, so a result passes through
// both registers. The summary height is one 16 by 10 bit multiply in the
// state update. Newlines, unknown kinds and glyphs while layout is disabled
// give no result and do not stall. Backpressure on the output stalls the
// input stage once the output register holds an untaken result.
module greedy_glyph_line_wrapper_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // code_point[20:0], advance[36:21], zero pad
  input  logic [gglw_pkg::IN_DATA_W-1:0]   s_tdata,
  // func[1:0]
  input  logic [gglw_pkg::IN_USER_W-1:0]   s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // placed_code_point[20:0], pos_x[36:21], pos_y[52:37], text_width[68:53],
  // text_height[84:69], total_lines[100:85], zero pad
  output logic [gglw_pkg::OUT_DATA_W-1:0]  m_tdata,
  // kind[0]
  output logic [gglw_pkg::OUT_USER_W-1:0]  m_tuser,
  input  logic                             cfg_we,
  input  logic [gglw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gglw_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import gglw_pkg::*;

  // configuration
  logic [7:0]  glyph_width;
  logic [7:0]  glyph_height;
  logic [7:0]  line_height;
  logic [7:0]  line_spacing;
  logic [15:0] wrap_width;

  // layout state
  logic [15:0] pen_x, pen_x_next;
  logic [15:0] pen_y, pen_y_next;
  logic [15:0] widest_line, widest_line_next;
  logic [15:0] line_total, line_total_next;

  // input stage
  logic            stage_valid;
  func_t           stage_func;
  logic [CP_W-1:0] stage_cp;
  logic [15:0]     stage_adv;

  logic advance_en;
  logic proc;

  // result
  logic            res_load;
  logic            res_kind;
  logic [CP_W-1:0] res_cp;
  logic [15:0]     res_x, res_y, res_w, res_h, res_n;

  // datapath helpers
  logic               enabled;
  logic [15:0]        widest_max;
  logic [15:0]        close_y;
  logic signed [17:0] limit;
  logic signed [17:0] adv_eff;
  logic signed [17:0] reach;
  logic               wrap;
  logic [15:0]        glyph_x;
  logic [15:0]        glyph_y;
  logic signed [9:0]  line_pitch;
  logic signed [26:0] pitch_prod;
  logic [15:0]        height;

  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_width  <= GLYPH_WIDTH_RST;
      glyph_height <= GLYPH_HEIGHT_RST;
      line_height  <= LINE_HEIGHT_RST;
      line_spacing <= LINE_SPACING_RST;
      wrap_width   <= WRAP_WIDTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GLYPH_WIDTH:  glyph_width  <= cfg_data[7:0];
        REG_GLYPH_HEIGHT: glyph_height <= cfg_data[7:0];
        REG_LINE_HEIGHT:  line_height  <= cfg_data[7:0];
        REG_LINE_SPACING: line_spacing <= cfg_data[7:0];
        REG_WRAP_WIDTH:   wrap_width   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign advance_en = !m_tvalid || m_tready;
  assign proc       = stage_valid && advance_en;
  assign s_tready   = !stage_valid || advance_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (s_tready) begin
      stage_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      stage_func <= func_t'(s_tuser);
      stage_cp   <= s_tdata[CP_W-1:0];
      stage_adv  <= s_tdata[CP_W+15:CP_W];
    end
  end

  assign enabled    = (glyph_width != 8'd0) && (glyph_height != 8'd0);
  assign widest_max = ($signed(pen_x) > $signed(widest_line)) ? pen_x : widest_line;
  assign close_y    = pen_y + {8'd0, line_height} + {{8{line_spacing[7]}}, line_spacing};

  assign limit   = ($signed(wrap_width) <= 16'sd0) ? $signed({10'd0, glyph_width})
                                                   : $signed({{2{wrap_width[15]}}, wrap_width});
  assign adv_eff = ($signed(stage_adv) <= 16'sd0) ? $signed({10'd0, glyph_width})
                                                  : $signed({{2{stage_adv[15]}}, stage_adv});
  assign reach   = $signed({{2{pen_x[15]}}, pen_x}) + adv_eff;
  assign wrap    = !pen_x[15] && (pen_x != 16'd0) && (reach > limit);
  assign glyph_x = wrap ? 16'd0 : pen_x;
  assign glyph_y = wrap ? close_y : pen_y;

  // lines*lh + (lines-1)*sp == lines*(lh+sp) - sp
  assign line_pitch = $signed({2'b00, line_height}) + $signed({{2{line_spacing[7]}}, line_spacing});
  assign pitch_prod = $signed({1'b0, line_total}) * line_pitch;
  assign height     = pitch_prod[15:0] - {{8{line_spacing[7]}}, line_spacing};

  always_comb begin
    pen_x_next       = pen_x;
    pen_y_next       = pen_y;
    widest_line_next = widest_line;
    line_total_next  = line_total;
    res_load         = 1'b0;
    res_kind         = KIND_GLYPH;
    res_cp           = '0;
    res_x            = '0;
    res_y            = '0;
    res_w            = '0;
    res_h            = '0;
    res_n            = '0;
    if (proc) begin
      unique case (stage_func)
        FUNC_END: begin
          res_load = 1'b1;
          res_kind = KIND_SUMMARY;
          if (enabled) begin
            res_w = widest_max;
            res_h = height;
            res_n = line_total;
          end
          pen_x_next       = '0;
          pen_y_next       = '0;
          widest_line_next = '0;
          line_total_next  = 16'd1;
        end
        FUNC_NEWLINE: begin
          if (enabled) begin
            widest_line_next = widest_max;
            pen_x_next       = '0;
            pen_y_next       = close_y;
            line_total_next  = line_total + 16'd1;
          end
        end
        FUNC_GLYPH: begin
          if (enabled) begin
            res_load = 1'b1;
            res_cp   = stage_cp;
            res_x    = glyph_x;
            res_y    = glyph_y;
            if (wrap) begin
              widest_line_next = widest_max;
              line_total_next  = line_total + 16'd1;
            end
            pen_y_next = glyph_y;
            pen_x_next = glyph_x + adv_eff[15:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pen_x       <= '0;
      pen_y       <= '0;
      widest_line <= '0;
      line_total  <= 16'd1;
    end else begin
      pen_x       <= pen_x_next;
      pen_y       <= pen_y_next;
      widest_line <= widest_line_next;
      line_total  <= line_total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      m_tuser <= res_kind;
      m_tdata <= {3'd0, res_n, res_h, res_w, res_y, res_x, res_cp};
    end
  end

  // a stalled input stage always holds a request
  assert property (@(posedge clk) disable iff (rst) !s_tready |-> stage_valid)
    else $error("input stalled with an empty stage");

  // end of text leaves a cleared layout state
  assert property (@(posedge clk) disable iff (rst)
    (proc && stage_func == FUNC_END) |=> (pen_x == 16'd0 && line_total == 16'd1))
    else $error("state not cleared after end of text");

  // a result is only loaded while the output register is free or draining
  assert property (@(posedge clk) disable iff (rst)
    res_load |-> (!m_tvalid || m_tready))
    else $error("result register overwritten");

endmodule
